// ----- rtl/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared widths, constants, types and helpers for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    localparam int HUE_W  = 13;
    localparam int FRAC_W = 8;
    localparam int REM_W  = 10;
    localparam int SR_W   = 18;
    localparam int NUM_W  = 26;
    localparam int PN_W   = 16;

    // hue units are 1/16 degree: full turn and one 60 degree sector
    localparam logic [HUE_W-1:0] HUE_TURN   = 13'd5760;
    localparam logic [REM_W-1:0] HUE_SECTOR = 10'd960;
    localparam logic [FRAC_W-1:0] FRAC_ONE  = 8'd255;
    // 255 * 960
    localparam logic [SR_W-1:0] DEN_FULL    = 18'd244800;

    // floor(n / 244800) = floor((n >> 6) * ceil(2^32 / 3825) >> 32) for n < 2^26
    localparam int DEN_SHIFT    = 6;
    localparam int QM_W         = NUM_W - DEN_SHIFT;
    localparam int RECIP_W      = 21;
    localparam int RECIP_SHIFT  = 32;
    localparam int RPROD_W      = QM_W + RECIP_W + 1;
    localparam logic [RECIP_W-1:0] RECIP = 21'd1122868;

    // floor(x / 255) = ((x + 1) * 257) >> 16 for x <= 255 * 255
    localparam int DIV_W = 26;
    localparam logic [8:0] DIV255_MUL = 9'd257;

    typedef logic [HUE_W-1:0]  t_hue;
    typedef logic [FRAC_W-1:0] t_frac;
    typedef logic [REM_W-1:0]  t_rem;

    typedef enum logic [2:0] {
        SECT_R_TO_Y = 3'd0,
        SECT_Y_TO_G = 3'd1,
        SECT_G_TO_C = 3'd2,
        SECT_C_TO_B = 3'd3,
        SECT_B_TO_M = 3'd4,
        SECT_M_TO_R = 3'd5
    } t_sector;

    // start hue of each sector
    function automatic t_hue sector_base(input t_sector sec);
        t_hue base;
        case (sec)
            SECT_R_TO_Y: base = 13'd0;
            SECT_Y_TO_G: base = 13'd960;
            SECT_G_TO_C: base = 13'd1920;
            SECT_C_TO_B: base = 13'd2880;
            SECT_B_TO_M: base = 13'd3840;
            SECT_M_TO_R: base = 13'd4800;
            default:     base = 13'd0;
        endcase
        return base;
    endfunction

endpackage

// ----- rtl/hsv2rgb_if.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_hsv_if / hsv2rgb_rgb_if
// Valid/ready pixel channels for HSV input beats and RGB output beats.
// ----------------------------------------------------------------------------
interface hsv2rgb_hsv_if;
    logic                 valid;
    logic                 ready;
    hsv2rgb_pkg::t_hue    hue;
    hsv2rgb_pkg::t_frac   saturation;
    hsv2rgb_pkg::t_frac   brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

interface hsv2rgb_rgb_if;
    logic                 valid;
    logic                 ready;
    hsv2rgb_pkg::t_frac   red;
    hsv2rgb_pkg::t_frac   green;
    hsv2rgb_pkg::t_frac   blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- rtl/hsv_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// An accepted HSV beat passes stage registers 1 to 5 to its RGB beat.
// Throughput: one beat per cycle unless stalled; five register stages, each
// with its own valid bit; a stage loads if empty or if its successor moves.
// Reset: synchronous active low, clears all stage valid bits only.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hsv2rgb_hsv_if.sink  i_hsv,
    hsv2rgb_rgb_if.source o_rgb
);
    import hsv2rgb_pkg::*;

    // stage enables, back to front
    logic s1_en, s2_en, s3_en, s4_en, s5_en;
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld;

    // stage 1: hue wrap, sector and offset in sector
    t_hue    h_wrap;
    t_hue    h_off;
    t_sector n_s1_sector, r_s1_sector;
    t_rem    n_s1_rem, r_s1_rem;
    t_frac   r_s1_sat, r_s1_val;
    logic    r_s1_gray;

    // stage 2: s*rem, s*(960-rem), v*(255-s)
    logic [SR_W-1:0] n_s2_srq, n_s2_srt, r_s2_srq, r_s2_srt;
    logic [PN_W-1:0] n_s2_pnum, r_s2_pnum;
    t_sector r_s2_sector;
    t_frac   r_s2_val;
    logic    r_s2_gray;

    // stage 3: numerators of q and t, p done
    logic [NUM_W-1:0] n_s3_nq, n_s3_nt, r_s3_nq, r_s3_nt;
    logic [DIV_W-1:0] p_prod;
    t_frac   n_s3_p, r_s3_p;
    t_sector r_s3_sector;
    t_frac   r_s3_val;
    logic    r_s3_gray;

    // stage 4: reciprocal multiply for q and t
    logic [RPROD_W-1:0] q_prod, t_prod;
    t_frac   n_s4_q, n_s4_t, r_s4_q, r_s4_t, r_s4_p;
    t_sector r_s4_sector;
    t_frac   r_s4_val;
    logic    r_s4_gray;

    // stage 5: channel select, output register
    t_frac n_s5_red, n_s5_green, n_s5_blue;
    t_frac r_s5_red, r_s5_green, r_s5_blue;

    assign s5_en = !r_s5_vld || o_rgb.ready;
    assign s4_en = !r_s4_vld || s5_en;
    assign s3_en = !r_s3_vld || s4_en;
    assign s2_en = !r_s2_vld || s3_en;
    assign s1_en = !r_s1_vld || s2_en;

    assign i_hsv.ready = s1_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
        end else begin
            if (s1_en) r_s1_vld <= i_hsv.valid;
            if (s2_en) r_s2_vld <= r_s1_vld;
            if (s3_en) r_s3_vld <= r_s2_vld;
            if (s4_en) r_s4_vld <= r_s3_vld;
            if (s5_en) r_s5_vld <= r_s4_vld;
        end
    end

    // ---- stage 1 ----
    always_comb begin
        h_wrap = (i_hsv.hue >= HUE_TURN) ? '0 : i_hsv.hue;
        if (h_wrap >= 13'd4800)      n_s1_sector = SECT_M_TO_R;
        else if (h_wrap >= 13'd3840) n_s1_sector = SECT_B_TO_M;
        else if (h_wrap >= 13'd2880) n_s1_sector = SECT_C_TO_B;
        else if (h_wrap >= 13'd1920) n_s1_sector = SECT_G_TO_C;
        else if (h_wrap >= 13'd960)  n_s1_sector = SECT_Y_TO_G;
        else                         n_s1_sector = SECT_R_TO_Y;
        h_off    = h_wrap - sector_base(n_s1_sector);
        n_s1_rem = h_off[REM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_s1_sector <= n_s1_sector;
            r_s1_rem    <= n_s1_rem;
            r_s1_sat    <= i_hsv.saturation;
            r_s1_val    <= i_hsv.brightness;
            r_s1_gray   <= (i_hsv.saturation == '0);
        end
    end

    // ---- stage 2 ----
    always_comb begin
        n_s2_srq  = SR_W'(r_s1_sat) * SR_W'(r_s1_rem);
        n_s2_srt  = SR_W'(r_s1_sat) * SR_W'(HUE_SECTOR - r_s1_rem);
        n_s2_pnum = PN_W'(r_s1_val) * PN_W'(FRAC_ONE - r_s1_sat);
    end

    always_ff @(posedge i_clk) begin
        if (s2_en) begin
            r_s2_srq    <= n_s2_srq;
            r_s2_srt    <= n_s2_srt;
            r_s2_pnum   <= n_s2_pnum;
            r_s2_sector <= r_s1_sector;
            r_s2_val    <= r_s1_val;
            r_s2_gray   <= r_s1_gray;
        end
    end

    // ---- stage 3 ----
    always_comb begin
        n_s3_nq = NUM_W'(r_s2_val) * NUM_W'(DEN_FULL - r_s2_srq);
        n_s3_nt = NUM_W'(r_s2_val) * NUM_W'(DEN_FULL - r_s2_srt);
        p_prod  = (DIV_W'(r_s2_pnum) + DIV_W'(1)) * DIV_W'(DIV255_MUL);
        n_s3_p  = p_prod[16 +: FRAC_W];
    end

    always_ff @(posedge i_clk) begin
        if (s3_en) begin
            r_s3_nq     <= n_s3_nq;
            r_s3_nt     <= n_s3_nt;
            r_s3_p      <= n_s3_p;
            r_s3_sector <= r_s2_sector;
            r_s3_val    <= r_s2_val;
            r_s3_gray   <= r_s2_gray;
        end
    end

    // ---- stage 4 ----
    always_comb begin
        q_prod = RPROD_W'(r_s3_nq[NUM_W-1:DEN_SHIFT]) * RPROD_W'(RECIP);
        t_prod = RPROD_W'(r_s3_nt[NUM_W-1:DEN_SHIFT]) * RPROD_W'(RECIP);
        n_s4_q = q_prod[RECIP_SHIFT +: FRAC_W];
        n_s4_t = t_prod[RECIP_SHIFT +: FRAC_W];
    end

    always_ff @(posedge i_clk) begin
        if (s4_en) begin
            r_s4_q      <= n_s4_q;
            r_s4_t      <= n_s4_t;
            r_s4_p      <= r_s3_p;
            r_s4_sector <= r_s3_sector;
            r_s4_val    <= r_s3_val;
            r_s4_gray   <= r_s3_gray;
        end
    end

    // ---- stage 5 ----
    always_comb begin
        if (r_s4_gray) begin
            n_s5_red   = r_s4_val;
            n_s5_green = r_s4_val;
            n_s5_blue  = r_s4_val;
        end else begin
            case (r_s4_sector)
                SECT_R_TO_Y: begin
                    n_s5_red = r_s4_val; n_s5_green = r_s4_t;   n_s5_blue = r_s4_p;
                end
                SECT_Y_TO_G: begin
                    n_s5_red = r_s4_q;   n_s5_green = r_s4_val; n_s5_blue = r_s4_p;
                end
                SECT_G_TO_C: begin
                    n_s5_red = r_s4_p;   n_s5_green = r_s4_val; n_s5_blue = r_s4_t;
                end
                SECT_C_TO_B: begin
                    n_s5_red = r_s4_p;   n_s5_green = r_s4_q;   n_s5_blue = r_s4_val;
                end
                SECT_B_TO_M: begin
                    n_s5_red = r_s4_t;   n_s5_green = r_s4_p;   n_s5_blue = r_s4_val;
                end
                default: begin
                    n_s5_red = r_s4_val; n_s5_green = r_s4_p;   n_s5_blue = r_s4_q;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s5_en) begin
            r_s5_red   <= n_s5_red;
            r_s5_green <= n_s5_green;
            r_s5_blue  <= n_s5_blue;
        end
    end

    assign o_rgb.valid = r_s5_vld;
    assign o_rgb.red   = r_s5_red;
    assign o_rgb.green = r_s5_green;
    assign o_rgb.blue  = r_s5_blue;

endmodule

// ----- rtl/hsv2rgb_checker.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// Port level checks for the HSV to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsv2rgb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input hsv2rgb_pkg::t_frac i_red,
    input hsv2rgb_pkg::t_frac i_green,
    input hsv2rgb_pkg::t_frac i_blue
);
    import hsv2rgb_pkg::*;

    // output beat held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_red) && $stable(i_green) && $stable(i_blue))
        else $error("output payload changed while stalled");

    // a free output slot lets the whole pipe move
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid || i_out_ready |-> i_in_ready)
        else $error("input stalled with output free");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output beat right after reset");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_hsv.ready),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_red       (o_rgb.red),
    .i_green     (o_rgb.green),
    .i_blue      (o_rgb.blue)
);
